FILE: design/rdq_pkg.sv
// package with shared constants and types for the reversible deque
`timescale 1ns / 1ps

package rdq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned STAT_W = 2;

  localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TOGGLE     = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic fetch;
  } dp_cmd_t;

endpackage

FILE: design/rdq_if.sv
// valid/ready channel interfaces for request and response transactions
`timescale 1ns / 1ps

interface rdq_in_if;
  logic                              valid;
  logic                              ready;
  logic [rdq_pkg::MODE_W-1:0]        mode;
  logic signed [rdq_pkg::WORD_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface rdq_out_if #(
  parameter int unsigned CNT_W = 7
);
  logic                              valid;
  logic                              ready;
  logic signed [rdq_pkg::WORD_W-1:0] front_value;
  logic signed [rdq_pkg::WORD_W-1:0] back_value;
  logic [CNT_W-1:0]                  count;
  logic [rdq_pkg::STAT_W-1:0]        status;

  modport source (output valid, output front_value, output back_value, output count,
                  output status, input ready);
  modport sink (input valid, input front_value, input back_value, input count,
                input status, output ready);
endinterface

FILE: design/rdq_ctrl.sv
// controller state machine sequencing capture, update, read and response
`timescale 1ns / 1ps

module rdq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output rdq_pkg::dp_cmd_t cmd
);

  rdq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rdq_pkg::S_IDLE: begin
        if (in_valid) state_next = rdq_pkg::S_EXEC;
      end
      rdq_pkg::S_EXEC: state_next = rdq_pkg::S_READ;
      rdq_pkg::S_READ: state_next = rdq_pkg::S_RESP;
      rdq_pkg::S_RESP: begin
        if (out_ready) state_next = rdq_pkg::S_IDLE;
      end
      default: state_next = rdq_pkg::S_IDLE;
    endcase
  end

  assign in_ready    = (state == rdq_pkg::S_IDLE) && !rst;
  assign out_valid   = (state == rdq_pkg::S_RESP);
  assign cmd.capture = in_ready && in_valid;
  assign cmd.execute = (state == rdq_pkg::S_EXEC);
  assign cmd.fetch   = (state == rdq_pkg::S_READ);

endmodule

FILE: design/rdq_datapath.sv
// datapath with word store, head and count pointers, reverse flag and result registers
`timescale 1ns / 1ps

module rdq_datapath #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned CW    = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rdq_pkg::dp_cmd_t                  cmd,
  input  logic [rdq_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [rdq_pkg::WORD_W-1:0] in_value,
  output logic signed [rdq_pkg::WORD_W-1:0] front_value,
  output logic signed [rdq_pkg::WORD_W-1:0] back_value,
  output logic [CW-1:0]                     count,
  output logic [rdq_pkg::STAT_W-1:0]        status
);

  localparam int unsigned SW = CW + 1;

  logic [rdq_pkg::WORD_W-1:0] mem [DEPTH];

  logic [rdq_pkg::MODE_W-1:0] mode;
  logic [rdq_pkg::WORD_W-1:0] value;
  logic [AW-1:0]              head, head_next;
  logic [CW-1:0]              cnt, cnt_next;
  logic                       reversed, reversed_next;
  logic [rdq_pkg::STAT_W-1:0] stat, stat_next;
  logic [rdq_pkg::WORD_W-1:0] hv, tv;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          empty, full, at_head;
  logic [AW-1:0] head_dec, head_inc, tail_ins, tail_addr;
  logic [SW-1:0] ins_sum, tail_sum;

  assign empty = (cnt == '0);
  assign full  = (cnt == CW'(DEPTH));

  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

  assign ins_sum  = SW'(head) + SW'(cnt);
  assign tail_ins = (ins_sum >= SW'(DEPTH)) ? AW'(ins_sum - SW'(DEPTH)) : AW'(ins_sum);

  assign tail_sum  = SW'(head) + SW'(cnt) - SW'(1);
  assign tail_addr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

  always_comb begin
    head_next     = head;
    cnt_next      = cnt;
    reversed_next = reversed;
    stat_next     = rdq_pkg::ST_OK;
    wr_en         = 1'b0;
    wr_addr       = tail_ins;
    at_head       = 1'b0;
    case (mode)
      rdq_pkg::MODE_PUSH_FRONT, rdq_pkg::MODE_PUSH_BACK: begin
        at_head = (mode == rdq_pkg::MODE_PUSH_FRONT) ^ reversed;
        if (full) begin
          stat_next = rdq_pkg::ST_FULL;
        end else begin
          wr_en    = 1'b1;
          cnt_next = cnt + CW'(1);
          if (at_head) begin
            if (!empty) head_next = head_dec;
            wr_addr = empty ? head : head_dec;
          end
        end
      end
      rdq_pkg::MODE_POP_FRONT, rdq_pkg::MODE_POP_BACK: begin
        at_head = (mode == rdq_pkg::MODE_POP_FRONT) ^ reversed;
        if (empty) begin
          stat_next = rdq_pkg::ST_EMPTY;
        end else begin
          cnt_next = cnt - CW'(1);
          if (at_head) head_next = head_inc;
        end
      end
      rdq_pkg::MODE_TOGGLE: reversed_next = !reversed;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      cnt      <= '0;
      reversed <= 1'b0;
    end else if (cmd.execute) begin
      head     <= head_next;
      cnt      <= cnt_next;
      reversed <= reversed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode  <= in_mode;
      value <= in_value;
    end
    if (cmd.execute) begin
      stat <= stat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && wr_en) begin
      mem[wr_addr] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      hv <= mem[head];
      tv <= mem[tail_addr];
    end
  end

  assign front_value = empty ? '1 : (reversed ? tv : hv);
  assign back_value  = empty ? '1 : (reversed ? hv : tv);
  assign count       = cnt;
  assign status      = stat;

endmodule

FILE: design/reversible_deque.sv
// top level of the reversible double-ended queue
//
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | mode, value
//  rsp     | out | valid / ready | front_value, back_value, count, status
//
// one transaction in flight; each passes through capture, pointer update with store write
// and registered store read before rsp is valid, then rsp holds until taken
// rst is synchronous: queue empty, head at zero, not reversed; store contents undefined
// req.ready is low from acceptance until the response transaction completes
`timescale 1ns / 1ps

module reversible_deque #(
  parameter int unsigned DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  rdq_in_if.sink     req,
  rdq_out_if.source  rsp
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rdq_pkg::dp_cmd_t cmd;

  rdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  rdq_datapath #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_mode     (req.mode),
    .in_value    (req.value),
    .front_value (rsp.front_value),
    .back_value  (rsp.back_value),
    .count       (rsp.count),
    .status      (rsp.status)
  );

endmodule

FILE: design/rdq_checker.sv
// port-level assertion checker for the reversible deque, bound to the top level
`timescale 1ns / 1ps

module rdq_checker #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned CW    = 7
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic signed [rdq_pkg::WORD_W-1:0] front_value,
  input logic signed [rdq_pkg::WORD_W-1:0] back_value,
  input logic [CW-1:0]                     count,
  input logic [rdq_pkg::STAT_W-1:0]        status
);

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while a transaction is in flight");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> count <= CW'(DEPTH))
    else $error("count beyond depth");

  a_empty_words: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && count == '0 |-> front_value == -32'sd1 && back_value == -32'sd1)
    else $error("empty queue reports words other than -1");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == rdq_pkg::ST_FULL |-> count == CW'(DEPTH))
    else $error("full status with queue not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == rdq_pkg::ST_EMPTY |-> count == '0)
    else $error("empty status with queue not empty");

endmodule

bind reversible_deque rdq_checker #(
  .DEPTH (DEPTH),
  .CW    ($clog2(DEPTH + 1))
) u_rdq_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .front_value (rsp.front_value),
  .back_value  (rsp.back_value),
  .count       (rsp.count),
  .status      (rsp.status)
);
